FILE: src/growable_free_list_allocator_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the growable free list allocator
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef GROWABLE_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH
`define GROWABLE_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is active.
`define GFLA_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("gfla: same-cycle check failed");
// Next-cycle implication, disabled while reset is active.
`define GFLA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("gfla: next-cycle check failed");
`else
`define GFLA_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define GFLA_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

FILE: src/gfla_pkg.sv
// ----------------------------------------------------------------------------
// gfla_pkg
// Field widths, operation and status codes shared by the allocator files.
// ----------------------------------------------------------------------------
`default_nettype none

package gfla_pkg;

    localparam int OP_W      = 2;
    localparam int NODE_W    = 10;
    localparam int STATUS_W  = 2;
    localparam int FREE_W    = 11;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    // Stream payload widths, rounded up to whole bytes.
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;
    localparam int M_PAD_W   = M_TDATA_W - STATUS_W - NODE_W - FREE_W;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_STEP = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_EXHAUSTED = 2'd1,
        STAT_NOT_INIT  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

endpackage

`default_nettype wire

FILE: src/gfla_link_ram.sv
// ----------------------------------------------------------------------------
// gfla_link_ram
// Next-link store: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module gfla_link_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 11,
    parameter int ADDR_W = 10
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // The read data holds until the next read, so a stalled consumer can
    // still pick it up later.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: src/growable_free_list_allocator_top.sv
// ----------------------------------------------------------------------------
// growable_free_list_allocator_top
// Fixed-size node pool with a LIFO free list that grows in blocks on demand.
// ----------------------------------------------------------------------------
// Usage: each transfer on the s_ channel carries one command (init, alloc,
// free or no-op) and produces exactly one result transfer on the m_ channel
// with a status, the allocated index and the free count. The first-block size
// register (index 0) and the growth step register (index 1) are written
// through cfg_wen, cfg_index and cfg_wdata while the block is idle; they take
// effect at the next init.
// Every command goes from the holding register to the result register
// directly, except an alloc whose head lies in a linked (freed) node: that
// one reads the link memory and waits in S_READ for the registered read
// data. Sustained throughput is one command per cycle while m_tready is high;
// such an alloc holds off the next command until its result is registered.
// A new block of nodes is never written to memory: it is kept as a range of
// implicitly ascending links and handed out by a bump pointer, so growth
// needs no memory access. After reset the pool is not initialized and the
// link memory needs no clearing pass. When m_tready is low, the finished
// result waits in the output register and one more command is taken into
// the holding register; further commands wait until the result moves on.
// ----------------------------------------------------------------------------
`default_nettype none

`include "growable_free_list_allocator_top_assert.svh"

module growable_free_list_allocator_top #(
    parameter int CAPACITY     = 1024,
    parameter int DEFAULT_BASE = 64,
    parameter int DEFAULT_STEP = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Command channel. s_tdata: opcode [1:0], node_index [11:2], zero pad.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [gfla_pkg::S_TDATA_W-1:0]  s_tdata,
    // Result channel. m_tdata: status [1:0], alloc_index [11:2],
    // free_nodes [22:12], zero pad.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [gfla_pkg::M_TDATA_W-1:0]  m_tdata,
    // Configuration write port.
    input  logic                            cfg_wen,
    input  logic [gfla_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gfla_pkg::CFG_W-1:0]      cfg_wdata
);

    import gfla_pkg::*;

    // Index width including the null code, and the memory address width.
    localparam int NW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    // Width of a block size: the configured value or a default.
    localparam int BW_W  = $clog2(DEFAULT_BASE + 1);
    localparam int ST_W  = $clog2(DEFAULT_STEP + 1);
    localparam int DEF_W = (BW_W > ST_W) ? BW_W : ST_W;
    localparam int CNT_W = (DEF_W > CFG_W) ? DEF_W : CFG_W;
    // Wide enough for a sum of an index and a block size without overflow.
    localparam int SUMW = ((NW > CNT_W) ? NW : CNT_W) + 1;

    localparam logic [NW-1:0]    NULL_LINK = NW'(CAPACITY);
    localparam logic [SUMW-1:0]  CAP_WIDE  = SUMW'(CAPACITY);
    localparam logic [CNT_W-1:0] DEF_BASE  = CNT_W'(DEFAULT_BASE);
    localparam logic [CNT_W-1:0] DEF_STEP  = CNT_W'(DEFAULT_STEP);

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    state_t             state_reg, state_next;

    // Holding register for one accepted command.
    logic               in_full_reg, in_full_next;
    opcode_t            in_op_reg;
    logic [NODE_W-1:0]  in_node_reg;

    // Output register.
    logic               m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // Configuration.
    logic [CFG_W-1:0]   first_blk_reg;
    logic [CFG_W-1:0]   grow_blk_reg;

    // Pool state.
    logic [NW-1:0]      head_reg, head_next;
    logic [NW-1:0]      free_total_reg, free_total_next;
    logic [NW-1:0]      hw_reg, hw_next;
    logic               pool_ready_reg, pool_ready_next;
    logic [CNT_W-1:0]   held_step_reg, held_step_next;

    // Fresh region: nodes bump..fend-1 link implicitly to their successor,
    // and the last of them links to tail_link. These nodes have never been
    // written in the link memory since their block was added.
    logic [NW-1:0]      bump_reg, bump_next;
    logic [NW-1:0]      fend_reg, fend_next;
    logic [NW-1:0]      tail_link_reg, tail_link_next;

    // ------------------------------------------------------------------
    // Link memory.
    // ------------------------------------------------------------------
    logic               ram_wr_en;
    logic               ram_rd_en;
    logic [NW-1:0]      ram_rd_data;

    // ------------------------------------------------------------------
    // Handshake.
    // ------------------------------------------------------------------
    logic               out_free;
    logic               result_fire;
    logic               s_accept;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    // The holding register is free, or its command completes this cycle.
    assign s_tready = !in_full_reg || result_fire;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // Datapath helpers.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]   base_sel;
    logic [CNT_W-1:0]   step_sel;
    logic [SUMW-1:0]    base_wide;
    logic               init_fits;
    logic [SUMW-1:0]    grow_end;
    logic               grow_fits;
    logic [SUMW-1:0]    free_sum;
    logic [NW-1:0]      free_sat;
    logic [NW-1:0]      free_dec;
    logic [NW-1:0]      free_inc;
    logic [NW-1:0]      hw_plus;
    logic [NW-1:0]      bump_plus;
    logic [NW-1:0]      fresh_head;
    logic               fresh_hit;
    logic [SUMW-1:0]    node_wide;
    logic [NW-1:0]      node_nw;
    logic               node_ok;
    logic               node_in_fresh;

    assign base_sel  = (first_blk_reg != '0) ? CNT_W'(first_blk_reg) : DEF_BASE;
    assign step_sel  = (grow_blk_reg != '0) ? CNT_W'(grow_blk_reg) : DEF_STEP;
    assign base_wide = SUMW'(base_sel);
    assign init_fits = base_wide <= CAP_WIDE;

    assign grow_end  = SUMW'(hw_reg) + SUMW'(held_step_reg);
    assign grow_fits = grow_end <= CAP_WIDE;
    assign free_sum  = SUMW'(free_total_reg) + SUMW'(held_step_reg);
    assign free_sat  = (free_sum > CAP_WIDE) ? NULL_LINK : free_sum[NW-1:0];
    assign free_dec  = (free_total_reg != '0) ? (free_total_reg - NW'(1)) : '0;
    assign free_inc  = (free_total_reg < NULL_LINK) ? (free_total_reg + NW'(1))
                                                    : free_total_reg;
    assign hw_plus   = hw_reg + NW'(1);

    assign bump_plus  = bump_reg + NW'(1);
    assign fresh_head = (bump_plus < fend_reg) ? bump_plus : tail_link_reg;
    assign fresh_hit  = (head_reg == bump_reg) && (bump_reg < fend_reg);

    assign node_wide     = SUMW'(in_node_reg);
    assign node_nw       = node_wide[NW-1:0];
    assign node_ok       = node_wide < CAP_WIDE;
    assign node_in_fresh = (node_nw >= bump_reg) && (node_nw < fend_reg);

    // ------------------------------------------------------------------
    // Command execution.
    // ------------------------------------------------------------------
    status_t            res_status;
    logic [NW-1:0]      res_index;
    logic [SUMW-1:0]    res_index_wide;
    logic [SUMW-1:0]    res_free_wide;

    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        free_total_next = free_total_reg;
        hw_next         = hw_reg;
        pool_ready_next = pool_ready_reg;
        held_step_next  = held_step_reg;
        bump_next       = bump_reg;
        fend_next       = fend_reg;
        tail_link_next  = tail_link_reg;
        res_status      = STAT_OK;
        res_index       = '0;
        result_fire     = 1'b0;
        ram_rd_en       = 1'b0;
        ram_wr_en       = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (in_full_reg && out_free) begin
                    case (in_op_reg)
                        OP_INIT: begin
                            result_fire    = 1'b1;
                            held_step_next = step_sel;
                            if (init_fits) begin
                                // The whole first block is fresh and ends the list.
                                head_next       = '0;
                                bump_next       = '0;
                                fend_next       = base_wide[NW-1:0];
                                tail_link_next  = NULL_LINK;
                                hw_next         = base_wide[NW-1:0];
                                free_total_next = base_wide[NW-1:0];
                                pool_ready_next = 1'b1;
                            end else begin
                                head_next       = NULL_LINK;
                                bump_next       = '0;
                                fend_next       = '0;
                                tail_link_next  = NULL_LINK;
                                hw_next         = '0;
                                free_total_next = '0;
                                pool_ready_next = 1'b0;
                                res_status      = STAT_EXHAUSTED;
                            end
                        end
                        OP_ALLOC: begin
                            if (!pool_ready_reg) begin
                                result_fire = 1'b1;
                                res_status  = STAT_NOT_INIT;
                            end else if (head_reg == NULL_LINK) begin
                                result_fire = 1'b1;
                                if (grow_fits) begin
                                    // Add a block above the high-water mark and
                                    // hand out its first node at once.
                                    res_index       = hw_reg;
                                    bump_next       = hw_plus;
                                    fend_next       = grow_end[NW-1:0];
                                    tail_link_next  = NULL_LINK;
                                    head_next       = (held_step_reg > CNT_W'(1))
                                                      ? hw_plus : NULL_LINK;
                                    hw_next         = grow_end[NW-1:0];
                                    free_total_next = free_sat - NW'(1);
                                end else begin
                                    res_status = STAT_EXHAUSTED;
                                end
                            end else if (fresh_hit) begin
                                result_fire     = 1'b1;
                                res_index       = head_reg;
                                head_next       = fresh_head;
                                bump_next       = bump_plus;
                                free_total_next = free_dec;
                            end else begin
                                // The head was linked explicitly: fetch its link.
                                ram_rd_en  = 1'b1;
                                state_next = S_READ;
                            end
                        end
                        OP_FREE: begin
                            result_fire = 1'b1;
                            if (!pool_ready_reg) begin
                                res_status = STAT_NOT_INIT;
                            end else if (node_ok) begin
                                ram_wr_en       = 1'b1;
                                head_next       = node_nw;
                                free_total_next = free_inc;
                                // A node inside the fresh region now has a stored
                                // link, so the fresh region stops just before it.
                                if (node_in_fresh) begin
                                    fend_next      = node_nw;
                                    tail_link_next = node_nw;
                                end
                            end
                        end
                        default: begin
                            result_fire = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                if (out_free) begin
                    result_fire     = 1'b1;
                    res_index       = head_reg;
                    head_next       = ram_rd_data;
                    free_total_next = free_dec;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res_index_wide = SUMW'(res_index);
    assign res_free_wide  = SUMW'(free_total_next);

    assign in_full_next  = s_accept ? 1'b1 : (result_fire ? 1'b0 : in_full_reg);
    assign m_tvalid_next = result_fire ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    gfla_link_ram #(
        .DEPTH  (CAPACITY),
        .WIDTH  (NW),
        .ADDR_W (AW)
    ) u_link_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (node_nw[AW-1:0]),
        .wr_data (head_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (head_reg[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            in_full_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            first_blk_reg  <= '0;
            grow_blk_reg   <= '0;
            head_reg       <= NULL_LINK;
            free_total_reg <= '0;
            hw_reg         <= '0;
            pool_ready_reg <= 1'b0;
            held_step_reg  <= DEF_STEP;
            bump_reg       <= '0;
            fend_reg       <= '0;
            tail_link_reg  <= NULL_LINK;
        end else begin
            state_reg      <= state_next;
            in_full_reg    <= in_full_next;
            m_tvalid_reg   <= m_tvalid_next;
            head_reg       <= head_next;
            free_total_reg <= free_total_next;
            hw_reg         <= hw_next;
            pool_ready_reg <= pool_ready_next;
            held_step_reg  <= held_step_next;
            bump_reg       <= bump_next;
            fend_reg       <= fend_next;
            tail_link_reg  <= tail_link_next;
            if (cfg_wen) begin
                case (cfg_index)
                    CFG_IDX_BASE: first_blk_reg <= cfg_wdata;
                    CFG_IDX_STEP: grow_blk_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_op_reg   <= opcode_t'(s_tdata[OP_W-1:0]);
            in_node_reg <= s_tdata[OP_W +: NODE_W];
        end
        if (result_fire) begin
            m_tdata_reg <= {{M_PAD_W{1'b0}},
                            res_free_wide[FREE_W-1:0],
                            res_index_wide[NODE_W-1:0],
                            res_status};
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `GFLA_ASSERT_IMPL(a_free_bound, aclk, aresetn, 1'b1, free_total_reg <= NULL_LINK)
    `GFLA_ASSERT_IMPL(a_fresh_region, aclk, aresetn, 1'b1,
        bump_reg <= fend_reg && fend_reg <= hw_reg && hw_reg <= NULL_LINK)
    `GFLA_ASSERT_IMPL(a_not_ready_empty, aclk, aresetn, !pool_ready_reg,
        head_reg == NULL_LINK && free_total_reg == '0)
    `GFLA_ASSERT_NEXT(a_read_then_wait, aclk, aresetn, ram_rd_en, state_reg == S_READ)
    `GFLA_ASSERT_IMPL(a_read_has_item, aclk, aresetn, state_reg == S_READ,
        in_full_reg && head_reg != NULL_LINK && pool_ready_reg)

endmodule

`default_nettype wire

FILE: dv/tb_growable_free_list_allocator_top.sv
// ----------------------------------------------------------------------------
// tb_growable_free_list_allocator_top
// Self-checking testbench for the growable free list allocator.
// ----------------------------------------------------------------------------
// The testbench keeps its own copy of the pool: the link array, the list head,
// the free count, the high-water mark and the held step size. When a command
// transfer is accepted, this copy works out the answer the block owes for it
// and queues that answer. A monitor compares every result transfer, field by
// field, with the oldest queued answer. A directed part covers the corner
// cases: use before init, a first block that is too large, growth that does
// not fit, free count saturation, frees above the high-water mark and
// re-init. Random traffic follows under several register settings and idle
// patterns, and a long receiver hold fills the block up.
// ----------------------------------------------------------------------------

module tb_growable_free_list_allocator_top;
    import gfla_pkg::*;

    localparam int POOL_CAP      = 1024;
    localparam int NULL_NODE     = POOL_CAP;
    localparam int DFLT_BASE     = 64;
    localparam int DFLT_STEP     = 32;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;

    // Result field positions in m_tdata, lowest bit first.
    localparam int ST_LSB   = 0;
    localparam int IDX_LSB  = ST_LSB + STATUS_W;
    localparam int FREE_LSB = IDX_LSB + NODE_W;

    typedef struct {
        status_t           status;
        logic [NODE_W-1:0] node;
        logic [FREE_W-1:0] free_nodes;
    } pool_answer_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_wen   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    growable_free_list_allocator_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Shadow copy of the pool and of the two registers.
    logic [FREE_W-1:0] pool_link [POOL_CAP];
    int unsigned       pool_head  = NULL_NODE;
    int unsigned       pool_free  = 0;
    int unsigned       pool_hwm   = 0;
    int unsigned       pool_step  = DFLT_STEP;
    bit                pool_ready = 1'b0;
    int unsigned       reg_base   = 0;
    int unsigned       reg_step   = 0;

    pool_answer_t pool_answer_q[$];
    int           live_nodes[$];
    int           err_cnt        = 0;
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;
    int           hold_request   = 0;
    int           hold_left      = 0;
    int unsigned  cycle_cnt      = 0;

    // Adds n nodes just above the high-water mark, linked in ascending order,
    // the last one pointing at the old head. Fails if the block does not fit.
    function automatic bit pool_grow(int unsigned n);
        int unsigned first;
        int unsigned i;
        first = pool_hwm;
        if (n > POOL_CAP || first > POOL_CAP - n)
            return 1'b0;
        for (i = 0; i < n; i++)
            pool_link[NODE_W'(first + i)] =
                FREE_W'((i + 1 < n) ? first + i + 1 : pool_head);
        if (n > 0)
            pool_head = first;
        pool_hwm  = first + n;
        pool_free = pool_free + n;
        if (pool_free > POOL_CAP)
            pool_free = POOL_CAP;
        return 1'b1;
    endfunction

    function automatic pool_answer_t pool_execute(opcode_t op, logic [NODE_W-1:0] node);
        pool_answer_t ans;
        int unsigned  got;
        ans.status = STAT_OK;
        got        = 0;
        case (op)
            OP_INIT: begin
                pool_step  = (reg_step != 0) ? reg_step : DFLT_STEP;
                pool_head  = NULL_NODE;
                pool_free  = 0;
                pool_hwm   = 0;
                pool_ready = 1'b0;
                if (pool_grow((reg_base != 0) ? reg_base : DFLT_BASE))
                    pool_ready = 1'b1;
                else
                    ans.status = STAT_EXHAUSTED;
            end
            OP_ALLOC: begin
                if (!pool_ready) begin
                    ans.status = STAT_NOT_INIT;
                end else if (pool_head >= NULL_NODE && !pool_grow(pool_step)) begin
                    ans.status = STAT_EXHAUSTED;
                end else if (pool_head < NULL_NODE) begin
                    got       = pool_head;
                    pool_head = 32'(pool_link[NODE_W'(got)]);
                    if (pool_free > 0)
                        pool_free--;
                end else begin
                    ans.status = STAT_EXHAUSTED;
                end
            end
            OP_FREE: begin
                // A 10-bit index is always inside the pool, so it is pushed.
                if (!pool_ready) begin
                    ans.status = STAT_NOT_INIT;
                end else begin
                    pool_link[node] = FREE_W'(pool_head);
                    pool_head       = 32'(node);
                    if (pool_free < POOL_CAP)
                        pool_free++;
                end
            end
            default: ;
        endcase
        ans.node       = got[NODE_W-1:0];
        ans.free_nodes = pool_free[FREE_W-1:0];
        return ans;
    endfunction

    // Offers one command, after a random idle gap, and records its answer
    // once the transfer is accepted. tvalid stays high for a following item.
    task automatic send_cmd(input opcode_t op, input logic [NODE_W-1:0] node,
                            output pool_answer_t ans);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - NODE_W - OP_W){1'b0}}, node, op};
        do
            @(posedge aclk);
        while (!s_tready);
        ans = pool_execute(op, node);
        pool_answer_q.push_back(ans);
    endtask

    task automatic send_simple(input opcode_t op, input logic [NODE_W-1:0] node);
        pool_answer_t ans;
        send_cmd(op, node, ans);
    endtask

    // Stops offering and waits until every queued answer has been seen.
    task automatic wait_all_answers();
        s_tvalid <= 1'b0;
        while (pool_answer_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        @(posedge aclk);
        if (idx == CFG_IDX_BASE)
            reg_base = 32'(value);
        else
            reg_step = 32'(value);
    endtask

    task automatic set_pool_config(input logic [CFG_W-1:0] base, input logic [CFG_W-1:0] step);
        wait_all_answers();
        cfg_write(CFG_IDX_BASE, base);
        cfg_write(CFG_IDX_STEP, step);
    endtask

    // Random commands: mostly allocs and frees of nodes that are out, with
    // some frees of arbitrary nodes, re-inits and no-ops mixed in.
    task automatic send_random_cmd();
        pool_answer_t        ans;
        opcode_t             op;
        logic [NODE_W-1:0]   node;
        int                  r;
        int                  k;
        r    = $urandom_range(99);
        node = NODE_W'($urandom_range(POOL_CAP - 1));
        if (r < 3)
            op = OP_INIT;
        else if (r < 6)
            op = OP_NOP;
        else if (r < 58)
            op = OP_ALLOC;
        else
            op = OP_FREE;
        if (op == OP_FREE && live_nodes.size() != 0 && $urandom_range(99) < 85) begin
            k    = $urandom_range(live_nodes.size() - 1);
            node = NODE_W'(live_nodes[k]);
            live_nodes.delete(k);
        end
        send_cmd(op, node, ans);
        if (op == OP_INIT)
            live_nodes.delete();
        if (op == OP_ALLOC && ans.status == STAT_OK)
            live_nodes.push_back(int'(ans.node));
    endtask

    // Receiver: a requested hold is counted down here, otherwise tready
    // stalls at random at the current rate.
    always @(posedge aclk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        pool_answer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pool_answer_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual tdata 0x%h",
                         $time, m_tdata);
                err_cnt++;
            end else begin
                want = pool_answer_q.pop_front();
                if (m_tdata[ST_LSB +: STATUS_W] !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, m_tdata[ST_LSB +: STATUS_W]);
                    err_cnt++;
                end
                if (m_tdata[IDX_LSB +: NODE_W] !== want.node) begin
                    $display("%0t: alloc_index mismatch, expected %0d, actual %0d",
                             $time, want.node, m_tdata[IDX_LSB +: NODE_W]);
                    err_cnt++;
                end
                if (m_tdata[FREE_LSB +: FREE_W] !== want.free_nodes) begin
                    $display("%0t: free_nodes mismatch, expected %0d, actual %0d",
                             $time, want.free_nodes, m_tdata[FREE_LSB +: FREE_W]);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge aclk)
        cycle_cnt <= cycle_cnt + 1;

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // Alloc, free and no-op before the first init.
    task automatic test_before_init();
        send_simple(OP_ALLOC, '0);
        send_simple(OP_FREE, '1);
        send_simple(OP_NOP, '1);
    endtask

    task automatic test_directed_cases();
        // A first block larger than the pool leaves it not ready.
        set_pool_config(11'h7FF, 11'd0);
        send_simple(OP_INIT, '0);
        send_simple(OP_ALLOC, '0);
        send_simple(OP_FREE, 10'd5);
        // One node, then a growth that can never fit.
        set_pool_config(11'd1, 11'h7FF);
        send_simple(OP_INIT, '0);
        send_simple(OP_ALLOC, '0);
        send_simple(OP_ALLOC, '0);
        send_simple(OP_FREE, '0);
        send_simple(OP_ALLOC, '1);
        // Full pool: a double free saturates the count; re-init while ready.
        set_pool_config(11'd1024, 11'd0);
        send_simple(OP_INIT, '0);
        send_simple(OP_FREE, 10'd1023);
        send_simple(OP_ALLOC, '0);
        send_simple(OP_ALLOC, '0);
        send_simple(OP_INIT, '1);
        // Defaults, with a free above the high-water mark.
        set_pool_config(11'd0, 11'd0);
        send_simple(OP_INIT, '0);
        send_simple(OP_ALLOC, '0);
        send_simple(OP_ALLOC, '0);
        send_simple(OP_FREE, '0);
        send_simple(OP_FREE, 10'd1023);
        send_simple(OP_ALLOC, '0);
        send_simple(OP_ALLOC, '0);
        send_simple(OP_NOP, '0);
    endtask

    // Two register settings per call, each followed by an init and traffic.
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int items, input int cfg_sel);
        logic [CFG_W-1:0] bases [8];
        logic [CFG_W-1:0] steps [8];
        int s;
        int n;
        bases = '{11'd0, 11'd1, 11'd2, 11'd1024, 11'd5, 11'd0, 11'd1, 11'd16};
        steps = '{11'd0, 11'd1, 11'd1024, 11'd0, 11'd3, 11'd1, 11'd7, 11'd2};
        wait_all_answers();
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (s = cfg_sel; s < cfg_sel + 2; s++) begin
            set_pool_config(bases[s], steps[s]);
            send_simple(OP_INIT, NODE_W'($urandom_range(POOL_CAP - 1)));
            live_nodes.delete();
            for (n = 0; n < items / 2; n++)
                send_random_cmd();
        end
    endtask

    // The receiver holds off while the sender keeps offering, so the block
    // fills up and stalls its input; then the sender waits for every answer.
    task automatic test_receiver_hold();
        int n;
        wait_all_answers();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_pool_config(CFG_W'($urandom_range(1, 8)), CFG_W'($urandom_range(1, 4)));
        send_simple(OP_INIT, '0);
        live_nodes.delete();
        hold_request = 300;
        for (n = 0; n < 40; n++)
            send_random_cmd();
        wait_all_answers();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_before_init();
        test_directed_cases();
        test_random_traffic(0, 0, 80, 0);
        test_random_traffic(82, 0, 80, 2);
        test_random_traffic(0, 82, 80, 4);
        test_random_traffic(29, 29, 80, 6);
        test_receiver_hold();
        wait_all_answers();
        if (err_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/gfla_pkg.sv
src/gfla_link_ram.sv
src/growable_free_list_allocator_top.sv
dv/tb_growable_free_list_allocator_top.sv
